FILE: rtl/tcw_pkg.sv
// tcw_pkg: request/response payload types and fixed codes of the text console writer.
// No dependencies; used by every module under rtl/.
package tcw_pkg;

	// Command codes carried in the request
	localparam logic [2:0] CMD_PUT   = 3'd0;
	localparam logic [2:0] CMD_BKSP  = 3'd1;
	localparam logic [2:0] CMD_CLEAR = 3'd2;
	localparam logic [2:0] CMD_SETCUR = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Control bytes handled by put char
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam int         TAB_STOP   = 8;
	localparam int         CELL_W     = 16;

	// Configuration port
	localparam int         CFG_ADDR_W    = 3;
	localparam logic       REG_TEXT_ATTR = 1'b0;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] char_code;
		logic [4:0] target_row;
		logic [6:0] target_col;
	} req_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_linear;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} rsp_t;

endpackage

FILE: rtl/tcw_cell_mem.sv
// tcw_cell_mem: screen cell store, one write port and one registered read port.
// Depends on tcw_pkg for the cell width.
module tcw_cell_mem #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [tcw_pkg::CELL_W-1:0]    wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [tcw_pkg::CELL_W-1:0]    rdata
);

	logic [tcw_pkg::CELL_W-1:0] cells_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			cells_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= cells_q[raddr];
		end
	end

endmodule

FILE: rtl/tcw_cfg_regs.sv
// tcw_cfg_regs: APB-style register block holding the text attribute.
// Depends on tcw_pkg for the address width and register index.
module tcw_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output logic [7:0]                        text_attr
);

	logic [7:0] attr_q;
	logic       reg_idx;

	assign reg_idx   = paddr[2];
	assign pready    = 1'b1;
	assign text_attr = attr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::RESET_ATTR;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == tcw_pkg::REG_TEXT_ATTR) begin
			attr_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == tcw_pkg::REG_TEXT_ATTR) begin
			prdata = {24'd0, attr_q};
		end
	end

endmodule

FILE: rtl/tcw_engine.sv
// tcw_engine: command sequencer, cursor state and shared address multiplier.
// Depends on tcw_pkg; drives the write and read ports of tcw_cell_mem.
module tcw_engine #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25,
	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT,
	localparam int AW    = $clog2(CELLS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  tcw_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output tcw_pkg::rsp_t                 rsp,
	input  logic [7:0]                    text_attr,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [tcw_pkg::CELL_W-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

	localparam int RW   = $clog2(SCREEN_HEIGHT + 1);
	localparam int CW   = $clog2(SCREEN_WIDTH);
	localparam int CNTW = $clog2(CELLS + 1);

	localparam logic [CNTW-1:0] CNT_END    = CNTW'(CELLS);
	localparam logic [CNTW-1:0] CNT_LAST   = CNTW'(CELLS - 1);
	localparam logic [CNTW-1:0] CNT_BOTTOM = CNTW'(CELLS - SCREEN_WIDTH);
	localparam logic [CNTW-1:0] CNT_ROW1   = CNTW'(SCREEN_WIDTH);
	localparam logic [RW-1:0]   ROW_END    = RW'(SCREEN_HEIGHT);
	localparam logic [RW-1:0]   ROW_LAST   = RW'(SCREEN_HEIGHT - 1);
	localparam logic [CW-1:0]   COL_LAST   = CW'(SCREEN_WIDTH - 1);
	localparam logic [CW:0]     TAB_STEP   = (CW+1)'(tcw_pkg::TAB_STOP);
	localparam logic [CW:0]     TAB_MASK   = ~((CW+1)'(tcw_pkg::TAB_STOP - 1));
	localparam logic [CW:0]     COL_END_X  = (CW+1)'(SCREEN_WIDTH);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DEC, S_ADR, S_PUTW, S_BSW, S_RD, S_RDC,
		S_CHK, S_SCR, S_SBLANK, S_FILL, S_FIN, S_OUT
	} state_t;

	state_t                     state_q;
	tcw_pkg::req_t              req_q;
	logic [RW-1:0]              row_q;
	logic [CW-1:0]              col_q;
	logic [AW-1:0]              lin_q;
	logic [CNTW-1:0]            cnt_q;
	logic [AW-1:0]              dst_q;
	logic                       scr_v_q;
	logic [tcw_pkg::CELL_W-1:0] cell_q;
	logic                       rsp_valid_q;
	tcw_pkg::rsp_t              rsp_q;

	logic [AW-1:0] mul_row;
	logic [AW-1:0] mul_col;
	logic [AW-1:0] lin_calc;
	logic [CW:0]   tab_col;
	logic          rd_ok;
	logic          row_ok;
	logic          col_ok;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign row_ok = 8'(req_q.target_row) < 8'(SCREEN_HEIGHT);
	assign col_ok = 9'(req_q.target_col) < 9'(SCREEN_WIDTH);
	assign rd_ok  = row_ok && col_ok;
	assign tab_col = ({1'b0, col_q} + TAB_STEP) & TAB_MASK;

	// Shared address unit: cursor or read target, row * width + column
	always_comb begin
		mul_row = AW'(row_q);
		mul_col = AW'(col_q);
		if (state_q == S_ADR && req_q.cmd == tcw_pkg::CMD_READ) begin
			mul_row = AW'(req_q.target_row);
			mul_col = AW'(req_q.target_col);
		end
		lin_calc = AW'(mul_row * AW'(SCREEN_WIDTH)) + mul_col;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lin_q;
		mem_wdata = {text_attr, tcw_pkg::BLANK_CHAR};
		mem_re    = 1'b0;
		mem_raddr = lin_q;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
			end
			S_FILL, S_SBLANK: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end
			S_PUTW: begin
				mem_we    = 1'b1;
				mem_wdata = {text_attr, req_q.char_code};
			end
			S_BSW: begin
				mem_we = 1'b1;
			end
			S_SCR: begin
				// read one row ahead, write the previous read back one row up
				mem_we    = scr_v_q;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
				mem_re    = (cnt_q != CNT_END);
				mem_raddr = cnt_q[AW-1:0];
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			req_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			lin_q       <= '0;
			cnt_q       <= '0;
			dst_q       <= '0;
			scr_v_q     <= 1'b0;
			cell_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// S_OUT reloads the register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cell_q <= '0;
					unique case (req_q.cmd)
						tcw_pkg::CMD_PUT: begin
							priority if (req_q.char_code == tcw_pkg::CH_LF) begin
								col_q   <= '0;
								row_q   <= row_q + 1'b1;
								state_q <= S_CHK;
							end else if (req_q.char_code == tcw_pkg::CH_CR) begin
								col_q   <= '0;
								state_q <= S_FIN;
							end else if (req_q.char_code == tcw_pkg::CH_TAB) begin
								if (tab_col >= COL_END_X) begin
									col_q <= '0;
									row_q <= row_q + 1'b1;
								end else begin
									col_q <= tab_col[CW-1:0];
								end
								state_q <= S_CHK;
							end else begin
								state_q <= S_ADR;
							end
						end
						tcw_pkg::CMD_BKSP: begin
							if (col_q != '0) begin
								col_q <= col_q - 1'b1;
							end else if (row_q != '0) begin
								row_q <= row_q - 1'b1;
								col_q <= COL_LAST;
							end
							state_q <= S_ADR;
						end
						tcw_pkg::CMD_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_FILL;
						end
						tcw_pkg::CMD_SETCUR: begin
							row_q   <= row_ok ? RW'(req_q.target_row) : ROW_LAST;
							col_q   <= col_ok ? CW'(req_q.target_col) : COL_LAST;
							state_q <= S_FIN;
						end
						tcw_pkg::CMD_READ: begin
							state_q <= rd_ok ? S_ADR : S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_ADR: begin
					lin_q <= lin_calc;
					unique case (req_q.cmd)
						tcw_pkg::CMD_PUT:  state_q <= S_PUTW;
						tcw_pkg::CMD_BKSP: state_q <= S_BSW;
						default:           state_q <= S_RD;
					endcase
				end
				S_PUTW: begin
					if (col_q == COL_LAST) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					state_q <= S_CHK;
				end
				S_BSW: begin
					state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= S_RDC;
				end
				S_RDC: begin
					cell_q  <= mem_rdata;
					state_q <= S_FIN;
				end
				S_CHK: begin
					if (row_q == ROW_END) begin
						cnt_q   <= CNT_ROW1;
						scr_v_q <= 1'b0;
						state_q <= S_SCR;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCR: begin
					if (cnt_q != CNT_END) begin
						scr_v_q <= 1'b1;
						dst_q   <= AW'(cnt_q - CNT_ROW1);
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						scr_v_q <= 1'b0;
						cnt_q   <= CNT_BOTTOM;
						state_q <= S_SBLANK;
					end
				end
				S_SBLANK: begin
					if (cnt_q == CNT_LAST) begin
						row_q   <= ROW_LAST;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FILL: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					lin_q   <= lin_calc;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.cursor_row    <= 5'(row_q);
						rsp_q.cursor_col    <= 7'(col_q);
						rsp_q.cursor_linear <= 11'(lin_q);
						rsp_q.cell_char     <= cell_q[7:0];
						rsp_q.cell_attr     <= cell_q[15:8];
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/text_console_writer.sv
// text_console_writer: top level of the text-mode console engine.
// Depends on tcw_pkg, tcw_cfg_regs, tcw_engine and tcw_cell_mem.
//
// Usage: a request (req, req_valid/req_stall) carries one command: put char,
// backspace, clear, set cursor or read cell. Each request yields exactly one
// response (rsp, rsp_valid/rsp_stall) with the cursor after the command and,
// for a read, the cell's character and attribute. text_attr is written over
// the APB-style port at address 0; the user must write it only while no
// request is in flight, and the block itself does not enforce this.
// Timing: one request at a time, run by a sequencer around one shared
// row*width+column unit and the cell store.
// Clear adds one store write per cell; a scroll copies the rows up and
// blanks the bottom row.
// Reset: cursor homes, text_attr returns to 0x07, and a clearing pass writes
// every cell to a space with attribute 0x07, one cell a cycle, with
// req_stall high.
// Stall: the response sits in an output register; the next request is still
// taken, and its response waits in the sequencer until the register is free.
module text_console_writer #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  tcw_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output tcw_pkg::rsp_t                     rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]                 text_attr;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [tcw_pkg::CELL_W-1:0] mem_rdata;

	tcw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.text_attr (text_attr)
	);

	tcw_engine #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.text_attr (text_attr),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcw_cell_mem #(
		.DEPTH (CELLS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
